[rtl/bfn_pkg.sv]
// ----------------------------------------------------------------------------
// bfn_pkg: shared definitions of the block flood NACK engine
// Event and command codes, packet type codes, reset values and the item
// structs carried by the input and result channels.
// ----------------------------------------------------------------------------
package bfn_pkg;

    localparam int CHUNK_BYTES_DEF = 64;

    localparam int TPS_W   = 15;
    localparam int VER_W   = 8;
    localparam int CHUNK_W = 16;
    localparam int LEN_W   = 7;
    localparam int TICK_W  = 16;
    localparam int OFF_W   = 22;

    localparam logic [TPS_W-1:0]  TPS_RESET         = 15'd128;
    localparam logic [TICK_W-1:0] SEND_PERIOD_RESET = 16'(128 / 2);

    localparam logic [7:0] PKT_DATA = 8'd0;
    localparam logic [7:0] PKT_NACK = 8'd1;

    typedef enum logic [2:0] {
        FN_DATA_RX  = 3'd0,
        FN_NACK_RX  = 3'd1,
        FN_SENT     = 3'd2,
        FN_START    = 3'd3,
        FN_RESTART  = 3'd4,
        FN_READ_RPL = 3'd5,
        FN_SET_VER  = 3'd6,
        FN_STOP     = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_WRITE  = 3'd1,
        ACT_NACK   = 3'd2,
        ACT_READ   = 3'd3,
        ACT_TIMER  = 3'd4,
        ACT_BCAST  = 3'd5,
        ACT_CANCEL = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        WF_NORMAL   = 2'd0,
        WF_NEW_FILE = 2'd1,
        WF_LAST     = 2'd2
    } t_wflag;

    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         pkt_type;
        logic [VER_W-1:0]   pkt_version;
        logic [CHUNK_W-1:0] pkt_chunk;
        logic [LEN_W-1:0]   pkt_len;
        logic [TICK_W-1:0]  interval;
        logic [LEN_W-1:0]   read_len;
        logic [VER_W-1:0]   new_version;
    } t_bfn_in;

    typedef struct packed {
        logic [2:0]         action;
        logic [1:0]         write_flag;
        logic [OFF_W-1:0]   byte_offset;
        logic [LEN_W-1:0]   byte_count;
        logic [VER_W-1:0]   hdr_version;
        logic [CHUNK_W-1:0] hdr_chunk;
        logic [TICK_W-1:0]  delay_ticks;
        logic [VER_W-1:0]   cur_version;
        logic               last;
    } t_bfn_out;

    // Build a command; cur_version and last are filled in by the caller.
    function automatic t_bfn_out mk_cmd(
        input t_action            act,
        input t_wflag             flag,
        input logic [OFF_W-1:0]   off,
        input logic [LEN_W-1:0]   cnt,
        input logic [VER_W-1:0]   hv,
        input logic [CHUNK_W-1:0] hc,
        input logic [TICK_W-1:0]  dly
    );
        t_bfn_out r;
        r.action      = act;
        r.write_flag  = flag;
        r.byte_offset = off;
        r.byte_count  = cnt;
        r.hdr_version = hv;
        r.hdr_chunk   = hc;
        r.delay_ticks = dly;
        r.cur_version = '0;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

[rtl/bfn_chan_if.sv]
// ----------------------------------------------------------------------------
// bfn_chan_if: valid/ready channel
// One transfer moves one payload item at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface bfn_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/block_flood_nack_engine_core.sv]
// ----------------------------------------------------------------------------
// block_flood_nack_engine_core: control engine of a NACK-driven block flood
// Flow: an event transfer lands in the input register; its commands are decoded
//   into the two-entry result register, which offers them on the result channel.
// Throughput: one event per cycle for events giving zero or one command while the
//   result channel is ready; after a two-command event, the next event with commands
//   waits until the result register, draining one command per cycle, is on its last.
// Reset (synchronous, active low): both channels empty, receiver role, version,
//   chunk and stored length zero, ticks per second 128, send period 64.
// ----------------------------------------------------------------------------
module block_flood_nack_engine_core #(
    parameter int CHUNK_BYTES = bfn_pkg::CHUNK_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bfn_pkg::TPS_W-1:0] i_cfg_wdata,
    bfn_chan_if.sink                  i_in,
    bfn_chan_if.source                o_out
);
    import bfn_pkg::*;

    localparam logic [31:0] CHUNK_U = 32'(CHUNK_BYTES);
    // Count field of a full-chunk read, truncated to the field width.
    localparam logic [LEN_W-1:0] CHUNK_CNT = CHUNK_U[LEN_W-1:0];

    // Byte offset of a chunk, kept to the offset field width.
    function automatic logic [OFF_W-1:0] f_offset(input logic [CHUNK_W-1:0] c);
        logic [31:0] prod;
        prod = 32'(c) * CHUNK_U;
        return prod[OFF_W-1:0];
    endfunction

    // Clamp a byte count to one chunk.
    function automatic logic [LEN_W-1:0] f_clamp(input logic [LEN_W-1:0] v);
        return (32'(v) > CHUNK_U) ? CHUNK_CNT : v;
    endfunction

    // ------------------------------------------------------------------
    // Configuration and protocol state
    // ------------------------------------------------------------------
    logic [TPS_W-1:0]   r_tps;
    logic [VER_W-1:0]   r_fv,  n_fv;
    logic [CHUNK_W-1:0] r_nc,  n_nc;
    logic [LEN_W-1:0]   r_sl,  n_sl;
    logic               r_snd, n_snd;
    logic [TICK_W-1:0]  r_sp,  n_sp;

    // Input register
    logic    r_in_v;
    t_bfn_in r_in;

    // Result register: two entries, shown from r_rd, r_cnt still to go
    t_bfn_out   r_res0, r_res1;
    logic [1:0] r_cnt;
    logic       r_rd;

    // Commands produced by the item in the input register
    t_bfn_out   n_res0, n_res1;
    logic [1:0] n_num;

    logic w_take;
    logic w_buf_free;
    logic w_adv;

    logic [LEN_W-1:0]  w_plen;
    logic [LEN_W-1:0]  w_rlen;
    logic [TICK_W-1:0] w_nack_dly;

    // ------------------------------------------------------------------
    // Event decode: new state and up to two commands
    // ------------------------------------------------------------------
    always_comb begin
        w_plen     = f_clamp(r_in.pkt_len);
        w_rlen     = f_clamp(r_in.read_len);
        w_nack_dly = {1'b0, r_sp[TICK_W-1:1]};

        n_fv   = r_fv;
        n_nc   = r_nc;
        n_sl   = r_sl;
        n_snd  = r_snd;
        n_sp   = r_sp;
        n_num  = 2'd0;
        n_res0 = mk_cmd(ACT_NONE, WF_NORMAL, '0, '0, '0, '0, '0);
        n_res1 = mk_cmd(ACT_NONE, WF_NORMAL, '0, '0, '0, '0, '0);

        case (t_func'(r_in.func))
            FN_DATA_RX: begin
                if (r_in.pkt_type == PKT_DATA) begin
                    if (r_in.pkt_version != r_fv) begin
                        // version change: restart reception from chunk 0
                        n_fv   = r_in.pkt_version;
                        n_nc   = '0;
                        n_num  = 2'd2;
                        n_res0 = mk_cmd(ACT_WRITE, WF_NEW_FILE, '0, '0, '0, '0, '0);
                        if (r_in.pkt_chunk != '0) begin
                            n_res1 = mk_cmd(ACT_NACK, WF_NORMAL, '0, '0,
                                            r_in.pkt_version, '0, w_nack_dly);
                        end else begin
                            n_res1 = mk_cmd(ACT_WRITE, WF_NORMAL, '0, w_plen,
                                            '0, '0, '0);
                            n_nc   = CHUNK_W'(1);
                        end
                    end else if (r_in.pkt_chunk == r_nc) begin
                        // in-order chunk: write it, short one ends the file
                        n_num  = 2'd1;
                        n_res0 = mk_cmd(ACT_WRITE,
                                        (32'(w_plen) < CHUNK_U) ? WF_LAST : WF_NORMAL,
                                        f_offset(r_nc), w_plen, '0, '0, '0);
                        n_nc   = r_nc + CHUNK_W'(1);
                    end else if (r_in.pkt_chunk > r_nc) begin
                        // gap ahead: ask for the expected chunk
                        n_num  = 2'd1;
                        n_res0 = mk_cmd(ACT_NACK, WF_NORMAL, '0, '0, r_fv, r_nc,
                                        w_nack_dly);
                    end
                end
            end
            FN_NACK_RX: begin
                if (r_in.pkt_type == PKT_NACK && r_snd) begin
                    // rewind to the requested chunk, or to 0 on foreign version
                    n_nc   = (r_in.pkt_version == r_fv) ? r_in.pkt_chunk : '0;
                    n_num  = 2'd2;
                    n_res0 = mk_cmd(ACT_READ, WF_NORMAL, f_offset(n_nc), CHUNK_CNT,
                                    '0, '0, '0);
                    n_res1 = mk_cmd(ACT_TIMER, WF_NORMAL, '0, '0, '0, '0, r_sp);
                end
            end
            FN_SENT: begin
                n_num = 2'd1;
                if (32'(r_sl) == CHUNK_U) begin
                    n_nc   = r_nc + CHUNK_W'(1);
                    n_res0 = mk_cmd(ACT_READ, WF_NORMAL, f_offset(n_nc), CHUNK_CNT,
                                    '0, '0, '0);
                end else begin
                    // file done: steady delay of two seconds
                    n_res0 = mk_cmd(ACT_TIMER, WF_NORMAL, '0, '0, '0, '0,
                                    {r_tps, 1'b0});
                end
            end
            FN_START: begin
                n_snd  = 1'b1;
                n_fv   = r_fv + VER_W'(2);
                n_nc   = '0;
                n_sp   = r_in.interval;
                n_num  = 2'd2;
                n_res0 = mk_cmd(ACT_READ, WF_NORMAL, '0, CHUNK_CNT, '0, '0, '0);
                n_res1 = mk_cmd(ACT_BCAST, WF_NORMAL, '0, '0, n_fv, '0,
                                r_in.interval);
            end
            FN_RESTART: begin
                n_nc   = '0;
                n_num  = 2'd1;
                n_res0 = mk_cmd(ACT_NACK, WF_NORMAL, '0, '0, r_fv, '0, w_nack_dly);
            end
            FN_READ_RPL: begin
                n_sl = w_rlen;
            end
            FN_SET_VER: begin
                n_fv = r_in.new_version;
            end
            FN_STOP: begin
                n_num  = 2'd1;
                n_res0 = mk_cmd(ACT_CANCEL, WF_NORMAL, '0, '0, '0, '0, '0);
            end
            default: begin
                n_num = 2'd0;
            end
        endcase

        // stamp the version after the event and mark the final command
        n_res0.cur_version = n_fv;
        n_res1.cur_version = n_fv;
        n_res0.last        = (n_num == 2'd1);
        n_res1.last        = 1'b1;
    end

    // ------------------------------------------------------------------
    // Handshake: advance the input register when its commands fit
    // ------------------------------------------------------------------
    assign w_take     = o_out.valid && o_out.ready;
    assign w_buf_free = (r_cnt == 2'd0) || (r_cnt == 2'd1 && w_take);
    assign w_adv      = r_in_v && ((n_num == 2'd0) || w_buf_free);

    assign i_in.ready  = !r_in_v || w_adv;
    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.data  = r_rd ? r_res1 : r_res0;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (i_cfg_we) begin
            r_tps <= i_cfg_wdata;
        end
    end

    // Protocol state: commit on advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv  <= '0;
            r_nc  <= '0;
            r_sl  <= '0;
            r_snd <= 1'b0;
            r_sp  <= SEND_PERIOD_RESET;
        end else if (w_adv) begin
            r_fv  <= n_fv;
            r_nc  <= n_nc;
            r_sl  <= n_sl;
            r_snd <= n_snd;
            r_sp  <= n_sp;
        end
    end

    // Input register: load on transfer, drop on advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_v <= 1'b1;
        end else if (w_adv) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // Result register: load a command pair, step to the second on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else if (w_adv && n_num != 2'd0) begin
            r_cnt <= n_num;
            r_rd  <= 1'b0;
        end else if (w_take) begin
            r_cnt <= r_cnt - 2'd1;
            r_rd  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && n_num != 2'd0) begin
            r_res0 <= n_res0;
            r_res1 <= n_res1;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result count out of range");

    a_last_matches_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.last == (r_cnt == 2'd1)))
        else $error("last flag does not match remaining commands");

    a_second_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_rd) |-> (r_cnt == 2'd1))
        else $error("second slot shown with two commands pending");

    a_pair_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !o_out.data.last) |=> o_out.valid)
        else $error("command pair broken after first transfer");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && !w_adv) |=> r_in_v)
        else $error("stalled event lost from input register");

endmodule

[test/bfn_flood_checker.sv]
// ----------------------------------------------------------------------------
// bfn_flood_checker: command predictor and scoreboard of the flood NACK engine
// Watch the event and command channels and the tick register port. Work out
// the commands that each accepted event must cause, then compare each
// accepted command field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module bfn_flood_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bfn_pkg::TPS_W-1:0] i_cfg_wdata,
    bfn_chan_if                       i_ev,
    bfn_chan_if                       i_cmd,
    output int                        o_cmds_pending,
    output int                        o_mismatch_cnt,
    output int                        o_cmds_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import bfn_pkg::*;

    localparam logic [LEN_W-1:0] FULL_CHUNK = LEN_W'(CHUNK_BYTES_DEF);

    // Engine state as the predictor sees it
    logic [TPS_W-1:0]   tps;
    logic [VER_W-1:0]   version;
    logic [CHUNK_W-1:0] next_chunk;
    logic [LEN_W-1:0]   stored_len;
    logic               sender;
    logic [TICK_W-1:0]  period;

    t_bfn_out cmd_due_q[$];
    int       mismatches = 0;
    int       checked    = 0;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        return (v > FULL_CHUNK) ? FULL_CHUNK : v;
    endfunction

    function automatic logic [OFF_W-1:0] chunk_offset(input logic [CHUNK_W-1:0] c);
        return OFF_W'(32'(c) * CHUNK_BYTES_DEF);
    endfunction

    function automatic t_bfn_out make_cmd(
        input t_action            act,
        input t_wflag             flag,
        input logic [OFF_W-1:0]   off,
        input logic [LEN_W-1:0]   cnt,
        input logic [VER_W-1:0]   hv,
        input logic [CHUNK_W-1:0] hc,
        input logic [TICK_W-1:0]  dly
    );
        t_bfn_out c;
        c = '0;
        c.action      = act;
        c.write_flag  = flag;
        c.byte_offset = off;
        c.byte_count  = cnt;
        c.hdr_version = hv;
        c.hdr_chunk   = hc;
        c.delay_ticks = dly;
        return c;
    endfunction

    function automatic t_bfn_out nack_cmd();
        return make_cmd(ACT_NACK, WF_NORMAL, '0, '0, version, next_chunk, period >> 1);
    endfunction

    function automatic t_bfn_out read_cmd();
        return make_cmd(ACT_READ, WF_NORMAL, chunk_offset(next_chunk), FULL_CHUNK,
                        '0, '0, '0);
    endfunction

    task automatic predict_commands(input t_bfn_in ev);
        t_bfn_out         cmds[$];
        t_bfn_out         c;
        logic [LEN_W-1:0] plen;
        logic [LEN_W-1:0] rlen;
        plen = clamp_len(ev.pkt_len);
        rlen = clamp_len(ev.read_len);
        case (ev.func)
            FN_DATA_RX: begin
                if (ev.pkt_type == PKT_DATA) begin
                    if (ev.pkt_version != version) begin
                        // restart reception on any version change
                        version    = ev.pkt_version;
                        next_chunk = '0;
                        cmds.push_back(make_cmd(ACT_WRITE, WF_NEW_FILE, '0, '0, '0, '0, '0));
                        if (ev.pkt_chunk != '0) begin
                            cmds.push_back(nack_cmd());
                        end else begin
                            cmds.push_back(make_cmd(ACT_WRITE, WF_NORMAL, '0, plen,
                                                    '0, '0, '0));
                            next_chunk = CHUNK_W'(1);
                        end
                    end else if (ev.pkt_chunk == next_chunk) begin
                        cmds.push_back(make_cmd(ACT_WRITE,
                                                (plen < FULL_CHUNK) ? WF_LAST : WF_NORMAL,
                                                chunk_offset(next_chunk), plen,
                                                '0, '0, '0));
                        next_chunk = next_chunk + 1'b1;
                    end else if (ev.pkt_chunk > next_chunk) begin
                        cmds.push_back(nack_cmd());
                    end
                end
            end
            FN_NACK_RX: begin
                if (ev.pkt_type == PKT_NACK && sender) begin
                    next_chunk = (ev.pkt_version == version) ? ev.pkt_chunk : '0;
                    cmds.push_back(read_cmd());
                    cmds.push_back(make_cmd(ACT_TIMER, WF_NORMAL, '0, '0, '0, '0, period));
                end
            end
            FN_SENT: begin
                if (stored_len == FULL_CHUNK) begin
                    next_chunk = next_chunk + 1'b1;
                    cmds.push_back(read_cmd());
                end else begin
                    cmds.push_back(make_cmd(ACT_TIMER, WF_NORMAL, '0, '0, '0, '0,
                                            {tps, 1'b0}));
                end
            end
            FN_START: begin
                sender     = 1'b1;
                version    = version + VER_W'(2);
                next_chunk = '0;
                period     = ev.interval;
                cmds.push_back(read_cmd());
                cmds.push_back(make_cmd(ACT_BCAST, WF_NORMAL, '0, '0, version, next_chunk,
                                        period));
            end
            FN_RESTART: begin
                next_chunk = '0;
                cmds.push_back(nack_cmd());
            end
            FN_READ_RPL: stored_len = rlen;
            FN_SET_VER:  version = ev.new_version;
            FN_STOP:     cmds.push_back(make_cmd(ACT_CANCEL, WF_NORMAL, '0, '0, '0, '0, '0));
            default: ;
        endcase
        foreach (cmds[i]) begin
            c             = cmds[i];
            c.cur_version = version;
            c.last        = (i == cmds.size() - 1);
            cmd_due_q.push_back(c);
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_bfn_out want;
        t_bfn_out got;
        if (!i_rst_n) begin
            tps        = TPS_RESET;
            version    = '0;
            next_chunk = '0;
            stored_len = '0;
            sender     = 1'b0;
            period     = SEND_PERIOD_RESET;
            cmd_due_q.delete();
        end else begin
            if (i_cfg_we) begin
                tps = i_cfg_wdata;
            end
            // compare before predicting: no command leaves in the cycle its event lands
            if (i_cmd.valid && i_cmd.ready) begin
                got = i_cmd.data;
                if (cmd_due_q.size() == 0) begin
                    $error("command with none due: action %0d", got.action);
                    mismatches++;
                end else begin
                    want = cmd_due_q.pop_front();
                    check_field("action", want.action, got.action);
                    check_field("write_flag", want.write_flag, got.write_flag);
                    check_field("byte_offset", want.byte_offset, got.byte_offset);
                    check_field("byte_count", want.byte_count, got.byte_count);
                    check_field("hdr_version", want.hdr_version, got.hdr_version);
                    check_field("hdr_chunk", want.hdr_chunk, got.hdr_chunk);
                    check_field("delay_ticks", want.delay_ticks, got.delay_ticks);
                    check_field("cur_version", want.cur_version, got.cur_version);
                    check_field("last", want.last, got.last);
                    checked++;
                end
            end
            if (i_ev.valid && i_ev.ready) begin
                predict_commands(i_ev.data);
            end
        end
        o_cmds_pending <= cmd_due_q.size();
        o_mismatch_cnt <= mismatches;
        o_cmds_checked <= checked;
    end

endmodule

[test/block_flood_nack_engine_core_tb.sv]
// ----------------------------------------------------------------------------
// block_flood_nack_engine_core_tb: testbench top of the flood NACK engine
// Drive a directed run of corner events, then phases of receiver streams,
// sender streams and random noise under several tick settings, with random stalls on
// both channels save in the last phase. A checker beside the engine predicts and compares.
// ----------------------------------------------------------------------------
module block_flood_nack_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfn_pkg::*;

    localparam int N_PHASES       = 7;
    localparam int PHASE_EVENTS   = 250;
    localparam int RX_HOLD_CYCLES = 200;     // long receiver hold, fills the engine
    localparam int SETTLE_CYCLES  = 4;       // engine may still hold an event with no command
    localparam int CYCLE_LIMIT    = 600000;

    bit                 clk    = 1'b0;
    logic               rst_n  = 1'b0;
    logic               cfg_we = 1'b0;
    logic [TPS_W-1:0]   cfg_wdata = '0;

    bit                 idle_on     = 1'b1;  // random gaps and stalls enabled
    bit                 rx_hold_req = 1'b0;  // ask the receiver for one long hold
    int unsigned        events_sent = 0;
    int                 cycles      = 0;
    int                 cmds_pending;
    int                 mismatch_cnt;
    int                 cmds_checked;
    logic [TPS_W-1:0]   tps_plan [N_PHASES];

    bfn_chan_if #(.t_payload(t_bfn_in))  ev_ch ();
    bfn_chan_if #(.t_payload(t_bfn_out)) cmd_ch ();

    block_flood_nack_engine_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (ev_ch),
        .o_out       (cmd_ch)
    );

    bfn_flood_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_ev           (ev_ch),
        .i_cmd          (cmd_ch),
        .o_cmds_pending (cmds_pending),
        .o_mismatch_cnt (mismatch_cnt),
        .o_cmds_checked (cmds_checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bound the run; a hang anywhere ends here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands still due", cycles,
                     cmds_pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Command receiver: ready stretches, random stall bursts and, once on
    // request, a long hold that backs the engine up into its event input.
    initial begin
        cmd_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                cmd_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                cmd_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end else begin
                cmd_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Every field random, packet type leaning to the two known codes.
    function automatic t_bfn_in random_ev();
        t_bfn_in e;
        e.func        = 3'($urandom_range(0, 7));
        e.pkt_type    = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(0, 1));
        e.pkt_version = VER_W'($urandom);
        e.pkt_chunk   = CHUNK_W'($urandom);
        e.pkt_len     = LEN_W'($urandom);
        e.interval    = TICK_W'($urandom);
        e.read_len    = LEN_W'($urandom);
        e.new_version = VER_W'($urandom);
        return e;
    endfunction

    // Offer one event and hold it until the transfer; valid stays high after
    // the transfer, so back-to-back events show no gap in valid.
    task automatic send_ev(input t_bfn_in e);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            ev_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        ev_ch.valid <= 1'b1;
        ev_ch.data  <= e;
        do @(posedge clk); while (!ev_ch.ready);
        events_sent++;
    endtask

    // Packet event (data or nack receive); unused fields stay random.
    task automatic send_pkt(input t_func fn, input logic [7:0] ptype,
                            input logic [VER_W-1:0] ver, input logic [CHUNK_W-1:0] chunk,
                            input logic [LEN_W-1:0] len);
        t_bfn_in e;
        e             = random_ev();
        e.func        = fn;
        e.pkt_type    = ptype;
        e.pkt_version = ver;
        e.pkt_chunk   = chunk;
        e.pkt_len     = len;
        send_ev(e);
    endtask

    // Control event; arg lands in whichever field the event uses.
    task automatic send_ctl(input t_func fn, input logic [15:0] arg);
        t_bfn_in e;
        e      = random_ev();
        e.func = fn;
        case (fn)
            FN_START:    e.interval    = arg;
            FN_READ_RPL: e.read_len    = arg[LEN_W-1:0];
            FN_SET_VER:  e.new_version = arg[VER_W-1:0];
            default: ;
        endcase
        send_ev(e);
    endtask

    // Drop valid and hold off until every due command has been taken.
    task automatic wait_drained();
        ev_ch.valid <= 1'b0;
        do @(posedge clk); while (cmds_pending != 0);
    endtask

    task automatic write_tps(input logic [TPS_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Corner events from reset: receiver first, then sender. Versions below
    // follow from the events before them.
    task automatic run_directed();
        send_pkt(FN_DATA_RX, 8'hA5, 8'd0, 16'd0, 7'd64);          // foreign type, ignore
        send_pkt(FN_NACK_RX, PKT_NACK, 8'd0, 16'd5, 7'd0);        // nack while receiving
        send_pkt(FN_DATA_RX, PKT_DATA, 8'd0, 16'd0, 7'd64);       // first chunk in order
        send_pkt(FN_DATA_RX, PKT_DATA, 8'd0, 16'd1, 7'h7F);       // oversized length
        send_pkt(FN_DATA_RX, PKT_DATA, 8'd0, 16'd0, 7'd64);       // old chunk
        send_pkt(FN_DATA_RX, PKT_DATA, 8'd0, 16'd9, 7'd64);       // chunk ahead, nack
        send_pkt(FN_DATA_RX, PKT_DATA, 8'd0, 16'd2, 7'd10);       // short, last chunk
        send_pkt(FN_DATA_RX, PKT_DATA, 8'hFF, 16'd0, 7'd0);       // new version at chunk 0
        send_pkt(FN_DATA_RX, PKT_DATA, 8'h07, 16'hFFFF, 7'd64);   // new version, far chunk
        send_ctl(FN_RESTART, 16'd0);
        send_ctl(FN_SET_VER, 16'h00FF);
        send_ctl(FN_START, 16'hFFFF);                             // version wraps to 1
        send_ctl(FN_READ_RPL, 16'd64);
        send_ctl(FN_SENT, 16'd0);                                 // full chunk, read next
        send_ctl(FN_READ_RPL, 16'h007F);                          // clamps to a full chunk
        send_pkt(FN_NACK_RX, PKT_NACK, 8'd1, 16'hFFFF, 7'd0);     // rewind to top chunk
        send_pkt(FN_DATA_RX, PKT_DATA, 8'd1, 16'hFFFF, 7'd64);    // chunk counter wraps
        send_ctl(FN_SENT, 16'd0);
        send_pkt(FN_NACK_RX, PKT_NACK, 8'h80, 16'd7, 7'd0);       // stale version, rewind to 0
        send_pkt(FN_NACK_RX, PKT_DATA, 8'd1, 16'd3, 7'd0);        // foreign type on nack
        send_ctl(FN_READ_RPL, 16'd3);
        send_ctl(FN_SENT, 16'd0);                                 // short chunk, steady timer
        send_ctl(FN_STOP, 16'd0);
        send_ctl(FN_START, 16'd0);
    endtask

    // Receiver stream: force a restart at a chosen version, then mostly
    // in-order chunks with duplicates, gaps, foreign packets and restarts.
    task automatic rx_stream();
        logic [VER_W-1:0]   ver;
        logic [CHUNK_W-1:0] nxt;
        ver = VER_W'($urandom);
        send_ctl(FN_SET_VER, 16'(ver ^ 8'h5A));
        send_pkt(FN_DATA_RX, PKT_DATA, ver, '0, 7'd64);
        nxt = 16'd1;
        repeat ($urandom_range(2, 24)) begin
            case ($urandom_range(0, 11))
                0: send_pkt(FN_DATA_RX, PKT_DATA, ver, nxt - 1'b1, 7'd64);
                1: send_pkt(FN_DATA_RX, PKT_DATA, ver, nxt + CHUNK_W'($urandom_range(1, 6)),
                            7'd64);
                2: send_pkt(FN_DATA_RX, 8'($urandom_range(2, 255)), ver, nxt, 7'd64);
                3: begin
                    send_pkt(FN_DATA_RX, PKT_DATA, ver, nxt, LEN_W'($urandom_range(0, 63)));
                    nxt++;
                end
                4: begin
                    send_pkt(FN_DATA_RX, PKT_DATA, ver, nxt, LEN_W'($urandom_range(65, 127)));
                    nxt++;
                end
                5: begin
                    send_ctl(FN_RESTART, 16'd0);
                    nxt = '0;
                end
                default: begin
                    send_pkt(FN_DATA_RX, PKT_DATA, ver, nxt, 7'd64);
                    nxt++;
                end
            endcase
        end
    endtask

    // Sender stream: start at a known version, then read replies and sent
    // confirmations, with nacks that rewind, go stale or carry a foreign type.
    task automatic tx_stream();
        logic [VER_W-1:0]  ver;
        logic [TICK_W-1:0] ival;
        ver = VER_W'($urandom);
        case ($urandom_range(0, 5))
            0:       ival = '0;
            1:       ival = '1;
            default: ival = TICK_W'($urandom);
        endcase
        send_ctl(FN_SET_VER, 16'(ver));
        send_ctl(FN_START, ival);
        ver = ver + 8'd2;
        repeat ($urandom_range(2, 16)) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_ctl(FN_READ_RPL, 16'($urandom_range(0, 63)));
                    send_ctl(FN_SENT, 16'd0);
                end
                1: send_pkt(FN_NACK_RX, PKT_NACK, ver, CHUNK_W'($urandom), LEN_W'($urandom));
                2: send_pkt(FN_NACK_RX, PKT_NACK, ver ^ VER_W'($urandom_range(1, 255)),
                            CHUNK_W'($urandom), LEN_W'($urandom));
                3: send_pkt(FN_NACK_RX, PKT_NACK, ver,
                            16'hFFFF - CHUNK_W'($urandom_range(0, 2)), LEN_W'($urandom));
                4: send_pkt(FN_NACK_RX, 8'($urandom_range(2, 255)), ver,
                            CHUNK_W'($urandom), LEN_W'($urandom));
                default: begin
                    send_ctl(FN_READ_RPL, 16'($urandom_range(64, 127)));
                    send_ctl(FN_SENT, 16'd0);
                end
            endcase
        end
        if ($urandom_range(0, 2) == 0) begin
            send_ctl(FN_STOP, 16'd0);
        end
    endtask

    // One phase of random traffic; optionally hold the receiver or drain
    // everything once midway.
    task automatic run_random(input int unsigned count, input bit long_hold,
                              input bit mid_drain);
        int unsigned stop_at;
        int unsigned mid;
        bit          done_mid;
        stop_at  = events_sent + count;
        mid      = events_sent + count / 2;
        done_mid = 1'b0;
        while (events_sent < stop_at) begin
            if (!done_mid && events_sent >= mid) begin
                done_mid = 1'b1;
                if (long_hold) begin
                    rx_hold_req = 1'b1;
                end
                if (mid_drain) begin
                    wait_drained();
                end
            end
            case ($urandom_range(0, 19)) inside
                [0:7]:   rx_stream();
                [8:14]:  tx_stream();
                default: repeat ($urandom_range(1, 4)) send_ev(random_ev());
            endcase
        end
    endtask

    // Stimulus and verdict
    initial begin
        ev_ch.valid <= 1'b0;
        ev_ch.data  <= '0;
        tps_plan = '{15'h7FFF, 15'd1, 15'd0, 15'h4000, TPS_W'($urandom),
                     TPS_W'($urandom_range(2, 32766)), TPS_RESET};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < N_PHASES; p++) begin
            // change the tick setting only with the engine empty
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            write_tps(tps_plan[p]);
            idle_on = (p != N_PHASES - 1);
            run_random(PHASE_EVENTS, p == 1, p == 2);
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d events, %0d commands compared, %0d tick settings",
                 events_sent, cmds_checked, N_PHASES);
        $display("receiver and sender streams, noise, long receiver hold, full drain");
        if (mismatch_cnt == 0 && cmds_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
